// ===== src/fm4r_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package fm4r_pkg;

    localparam int NUM_CFG   = 8;
    localparam int CFG_IDX_W = $clog2(NUM_CFG);
    localparam int CFG_W     = 64;

    typedef logic [31:0] f32_t;

    localparam f32_t CANON_NAN = 32'h7FC0_0000;

    localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
        64'h0000_0000_3F80_0000, 64'h0,
        64'h3F80_0000_0000_0000, 64'h0,
        64'h0, 64'h0000_0000_3F80_0000,
        64'h0, 64'h3F80_0000_0000_0000
    };

    typedef struct packed {
        f32_t [3:0] x;
        f32_t [3:0] acc;
    } row_t;

    // value = mag * 2^(ex - 127 - 46) unless nan or inf
    typedef struct packed {
        logic               sign;
        logic               nan;
        logic               inf;
        logic signed [10:0] ex;
        logic [47:0]        mag;
    } raw_t;

    function automatic logic [5:0] lead_one(input logic [47:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) p = 6'(i);
        end
        return p;
    endfunction

    function automatic raw_t fp_mul_raw(input f32_t a, input f32_t b);
        raw_t       r;
        logic [7:0] ea, eb;
        logic       a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        logic [23:0] ma, mb;
        ea     = a[30:23];
        eb     = b[30:23];
        a_nan  = (ea == 8'hFF) && (a[22:0] != '0);
        b_nan  = (eb == 8'hFF) && (b[22:0] != '0);
        a_inf  = (ea == 8'hFF) && (a[22:0] == '0);
        b_inf  = (eb == 8'hFF) && (b[22:0] == '0);
        a_zero = (a[30:0] == '0);
        b_zero = (b[30:0] == '0);
        ma     = {ea != 8'h0, a[22:0]};
        mb     = {eb != 8'h0, b[22:0]};
        r.nan  = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
        r.inf  = (a_inf | b_inf) & ~r.nan;
        r.sign = a[31] ^ b[31];
        r.mag  = ma * mb;
        r.ex   = $signed({3'b0, ((ea == 8'h0) ? 8'h1 : ea)})
               + $signed({3'b0, ((eb == 8'h0) ? 8'h1 : eb)}) - 11'sd127;
        return r;
    endfunction

    function automatic raw_t fp_add_raw(input f32_t a, input f32_t b);
        raw_t        r;
        logic [7:0]  ea, eb, xa, xb, xbig, xsm, d;
        logic        a_nan, b_nan, a_inf, b_inf, swap, sbig, ssm;
        logic [23:0] ma, mb, mbig, msm;
        logic [26:0] bs, sm_ext;
        logic [27:0] s;
        ea     = a[30:23];
        eb     = b[30:23];
        a_nan  = (ea == 8'hFF) && (a[22:0] != '0);
        b_nan  = (eb == 8'hFF) && (b[22:0] != '0);
        a_inf  = (ea == 8'hFF) && (a[22:0] == '0);
        b_inf  = (eb == 8'hFF) && (b[22:0] == '0);
        ma     = {ea != 8'h0, a[22:0]};
        mb     = {eb != 8'h0, b[22:0]};
        xa     = (ea == 8'h0) ? 8'h1 : ea;
        xb     = (eb == 8'h0) ? 8'h1 : eb;
        swap   = a[30:0] < b[30:0];
        xbig   = swap ? xb : xa;
        xsm    = swap ? xa : xb;
        mbig   = swap ? mb : ma;
        msm    = swap ? ma : mb;
        sbig   = swap ? b[31] : a[31];
        ssm    = swap ? a[31] : b[31];
        d      = xbig - xsm;
        sm_ext = {msm, 3'b0};
        if (d >= 8'd27) begin
            bs = {26'b0, |msm};
        end else begin
            bs = (sm_ext >> d)
               | {26'b0, |(sm_ext & ~(27'h7FF_FFFF << d))};
        end
        if (sbig ^ ssm) s = {1'b0, mbig, 3'b0} - {1'b0, bs};
        else            s = {1'b0, mbig, 3'b0} + {1'b0, bs};
        r.nan = a_nan | b_nan | (a_inf & b_inf & (a[31] != b[31]));
        r.inf = (a_inf | b_inf) & ~r.nan;
        r.mag = {s, 20'b0};
        r.ex  = $signed({3'b0, xbig});
        if (a_inf | b_inf)  r.sign = a_inf ? a[31] : b[31];
        else if (s == '0)   r.sign = a[31] & b[31];
        else                r.sign = sbig;
        return r;
    endfunction

    function automatic f32_t fp_round(input raw_t r);
        logic [5:0]         l;
        logic signed [10:0] eb, e0, e1;
        logic [47:0]        norm;
        logic [6:0]         sh;
        logic [95:0]        w;
        logic [23:0]        mant;
        logic               g, st, inc;
        logic [24:0]        m25;
        f32_t               res;
        l    = lead_one(r.mag);
        eb   = r.ex + $signed({5'b0, l}) - 11'sd46;
        norm = r.mag << (6'd47 - l);
        if (eb < 11'sd1) begin
            if (eb < -11'sd95) sh = 7'd96;
            else               sh = 7'(11'sd1 - eb);
            w  = {norm, 48'b0} >> sh;
            e0 = '0;
        end else begin
            w  = {norm, 48'b0};
            e0 = eb;
        end
        mant = w[95:72];
        g    = w[71];
        st   = |w[70:0];
        inc  = g & (st | mant[0]);
        m25  = {1'b0, mant} + {24'b0, inc};
        if (m25[24]) begin
            mant = 24'h80_0000;
            e1   = e0 + 11'sd1;
        end else begin
            mant = m25[23:0];
            e1   = ((e0 == 11'sd0) && mant[23]) ? 11'sd1 : e0;
        end
        if (r.nan)                           res = CANON_NAN;
        else if (r.inf || (e1 >= 11'sd255))  res = {r.sign, 8'hFF, 23'b0};
        else if (r.mag == '0)                res = {r.sign, 31'b0};
        else                                 res = {r.sign, e1[7:0], mant[22:0]};
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== src/fm4r_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface fm4r_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] row_x0;
    logic [31:0] row_x1;
    logic [31:0] row_x2;
    logic [31:0] row_x3;
    modport source (output valid, output row_x0, output row_x1, output row_x2,
                    output row_x3, input ready);
    modport sink   (input valid, input row_x0, input row_x1, input row_x2,
                    input row_x3, output ready);
endinterface
`default_nettype wire

// ===== src/fm4r_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface fm4r_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_y0;
    logic [31:0] out_y1;
    logic [31:0] out_y2;
    logic [31:0] out_y3;
    modport source (output valid, output out_y0, output out_y1, output out_y2,
                     output out_y3, input ready);
    modport sink   (input valid, input out_y0, input out_y1, input out_y2,
                    input out_y3, output ready);
endinterface
`default_nettype wire

// ===== src/fm4r_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fm4r_cell
    import fm4r_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire f32_t [3:0] m_row,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire row_t       in_row,
    output logic            out_valid,
    input  wire logic       out_ready,
    output row_t            out_row
);

    logic [3:0] v_reg;
    logic [3:0] en;
    row_t       row_reg  [4];
    raw_t       prod_reg [4];
    f32_t       p_reg    [4];
    raw_t       sum_reg  [4];

    always_comb
    begin
        en[3] = ~v_reg[3] | out_ready;
        en[2] = ~v_reg[2] | en[3];
        en[1] = ~v_reg[1] | en[2];
        en[0] = ~v_reg[0] | en[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0]) v_reg[0] <= in_valid;
            for (int k = 1; k < 4; k++)
            begin
                if (en[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            row_reg[0] <= in_row;
            for (int j = 0; j < 4; j++)
            begin
                prod_reg[j] <= fp_mul_raw(in_row.x[0], m_row[j]);
            end
        end
        if (en[1])
        begin
            row_reg[1] <= row_reg[0];
            for (int j = 0; j < 4; j++)
            begin
                p_reg[j] <= fp_round(prod_reg[j]);
            end
        end
        if (en[2])
        begin
            row_reg[2] <= row_reg[1];
            for (int j = 0; j < 4; j++)
            begin
                sum_reg[j] <= fp_add_raw(row_reg[1].acc[j], p_reg[j]);
            end
        end
        if (en[3])
        begin
            row_reg[3].x <= {32'h0, row_reg[2].x[3:1]};
            for (int j = 0; j < 4; j++)
            begin
                row_reg[3].acc[j] <= fp_round(sum_reg[j]);
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[3];
    assign out_row   = row_reg[3];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[3] && !out_ready |=> v_reg[3] && $stable(row_reg[3]))
        else $error("stalled result changed");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("cell stalled while downstream ready");
    a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[1] |-> in_ready)
        else $error("cell stalled with empty stage");

endmodule
`default_nettype wire

// ===== src/float_4x4_row_transform.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Row vector times 4x4 binary32 matrix, one row per transaction. Each of four
// cells takes one input element, multiplies it with one matrix row and adds
// the products to four running sums: multiply, product round, add, sum round,
// one stage each. A new row is taken every cycle while the result side keeps
// up. Every product and sum is rounded to nearest even, subnormals are kept,
// NaN results come out as 0x7FC00000. Matrix register 2*r+h holds row r,
// columns 2h (bits 31:0) and 2h+1 (bits 63:32); reset loads the identity.
// Write the matrix only while no row is in flight.
module float_4x4_row_transform
    import fm4r_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    fm4r_in_if.sink                   rows,
    fm4r_out_if.source                results
);

    logic [CFG_W-1:0] cfg_reg [NUM_CFG];
    f32_t [3:0]       m_row   [4];
    logic             vld     [5];
    logic             rdy     [5];
    row_t             chain   [5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CFG; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                m_row[i][j] = cfg_reg[2*i + j/2][(j%2)*32 +: 32];
            end
        end
    end

    assign vld[0]       = rows.valid;
    assign rows.ready   = rdy[0];
    assign chain[0].x   = {rows.row_x3, rows.row_x2, rows.row_x1, rows.row_x0};
    assign chain[0].acc = '0;

    for (genvar c = 0; c < 4; c++)
    begin : g_cell
        fm4r_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .m_row     (m_row[c]),
            .in_valid  (vld[c]),
            .in_ready  (rdy[c]),
            .in_row    (chain[c]),
            .out_valid (vld[c+1]),
            .out_ready (rdy[c+1]),
            .out_row   (chain[c+1])
        );
    end

    assign rdy[4]         = results.ready;
    assign results.valid  = vld[4];
    assign results.out_y0 = chain[4].acc[0];
    assign results.out_y1 = chain[4].acc[1];
    assign results.out_y2 = chain[4].acc[2];
    assign results.out_y3 = chain[4].acc[3];

endmodule
`default_nettype wire
